@@ src/indexed_list_engine_defines.svh @@
// ----------------------------------------------------------------------------
// indexed_list_engine_defines.svh
// Assertion macros used by the indexed list engine controller.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ILE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define ILE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_pkg
// Types and constants shared by the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

	// Default geometry
	localparam int DEPTH_DEF    = 64;
	localparam int ELEM_W_DEF   = 32;

	// Fixed field widths
	localparam int CAP_W        = 7;
	localparam int INDEX_W      = 7;
	localparam int VALUE_W      = 32;
	localparam int MATCH_W      = 6;
	localparam int COUNT_W      = 7;

	localparam logic [CAP_W-1:0] LIMIT_RESET = 7'd64;

	// Request codes
	typedef enum logic [2:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_INSERT = 3'd2,
		ACT_ERASE  = 3'd3,
		ACT_GET    = 3'd4,
		ACT_SET    = 3'd5,
		ACT_FIND   = 3'd6,
		ACT_CLEAR  = 3'd7
	} action_t;

	// Per-cycle command to every cell of the row
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_ROT_DN,
		CELL_ROT_UP,
		CELL_INSERT,
		CELL_ERASE,
		CELL_WRITE
	} cell_op_t;

	typedef struct packed {
		action_t              action;
		logic [INDEX_W-1:0]   index;
		logic [VALUE_W-1:0]   value;
	} in_item_t;

	typedef struct packed {
		logic                 ok;
		logic [VALUE_W-1:0]   read_value;
		logic [MATCH_W-1:0]   match_index;
		logic [COUNT_W-1:0]   count_now;
	} out_item_t;

endpackage

@@ src/ile_cell.sv @@
// ----------------------------------------------------------------------------
// ile_cell
// One list element: takes its value from a neighbor, the write data, or holds.
// ----------------------------------------------------------------------------
module ile_cell #(
	parameter int ELEMENT_WIDTH = 32,
	parameter int CW            = 7
) (
	input  logic                     clk,
	input  ile_pkg::cell_op_t        op,
	input  logic [CW-1:0]            pos,
	input  logic [CW-1:0]            idx,
	input  logic [CW-1:0]            cnt,
	input  logic [ELEMENT_WIDTH-1:0] wdata,
	input  logic [ELEMENT_WIDTH-1:0] up,
	input  logic [ELEMENT_WIDTH-1:0] dn,
	output logic [ELEMENT_WIDTH-1:0] q
);
	import ile_pkg::*;

	logic [ELEMENT_WIDTH-1:0] elem_q;
	logic [ELEMENT_WIDTH-1:0] elem_d;

	// Select the next value from the row command and this cell's position
	always_comb begin
		elem_d = elem_q;
		unique case (op)
			CELL_HOLD: begin
				elem_d = elem_q;
			end
			CELL_ROT_DN: begin
				elem_d = up;
			end
			CELL_ROT_UP: begin
				elem_d = dn;
			end
			CELL_INSERT: begin
				if (pos == idx) begin
					elem_d = wdata;
				end else if (pos > idx && pos <= cnt) begin
					elem_d = dn;
				end
			end
			CELL_ERASE: begin
				if (pos >= idx && pos + CW'(1) < cnt) begin
					elem_d = up;
				end
			end
			CELL_WRITE: begin
				if (pos == idx) begin
					elem_d = wdata;
				end
			end
			default: begin
				elem_d = elem_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		elem_q <= elem_d;
	end

	assign q = elem_q;

endmodule

@@ src/ile_ctrl.sv @@
// ----------------------------------------------------------------------------
// ile_ctrl
// Request decode, element count, ring scan sequencer and result register.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_defines.svh"

module ile_ctrl #(
	parameter int DEPTH         = 64,
	parameter int ELEMENT_WIDTH = 32,
	parameter int CW            = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ile_pkg::CAP_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ile_pkg::in_item_t                 in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ile_pkg::out_item_t                out_item,
	input  logic [ELEMENT_WIDTH-1:0]          head,
	output ile_pkg::cell_op_t                 cell_op,
	output logic [CW-1:0]                     cell_idx,
	output logic [CW-1:0]                     cell_cnt,
	output logic [ELEMENT_WIDTH-1:0]          cell_wdata
);
	import ile_pkg::*;

	localparam int CMP_W = (CW > CAP_W) ? CW : ((CAP_W > INDEX_W) ? CAP_W : INDEX_W);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_FWD  = 4'b0010,
		ST_BACK = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t                   state_q, state_d;
	logic [CW-1:0]            n_q, n_d;
	logic [CW-1:0]            s_q, s_d;
	logic [CW-1:0]            tgt_q, tgt_d;
	logic                     find_q, find_d;
	logic [ELEMENT_WIDTH-1:0] key_q, key_d;
	logic [CAP_W-1:0]         cap_q;
	out_item_t                res_q, res_d;
	out_item_t                out_q;
	logic                     out_valid_q;

	logic                     accept;
	logic                     out_free;
	logic                     deliver;
	out_item_t                deliver_res;
	logic [ELEMENT_WIDTH-1:0] wval;
	logic [CMP_W-1:0]         idx_w, n_w, eff_w, cap_w, depth_w;
	logic                     can_grow, idx_lt, idx_le;
	logic                     imm_done;
	out_item_t                imm_res;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Bounds checks at a common width
	assign wval     = ELEMENT_WIDTH'(in_item.value);
	assign idx_w    = CMP_W'(in_item.index);
	assign n_w      = CMP_W'(n_q);
	assign cap_w    = CMP_W'(cap_q);
	assign depth_w  = CMP_W'(DEPTH);
	assign eff_w    = (cap_w < depth_w) ? cap_w : depth_w;
	assign can_grow = n_w < eff_w;
	assign idx_lt   = idx_w < n_w;
	assign idx_le   = idx_w <= n_w;

	// Decode, sequence the ring scan and pick the result to deliver
	always_comb begin
		state_d     = state_q;
		n_d         = n_q;
		s_d         = s_q;
		tgt_d       = tgt_q;
		find_d      = find_q;
		key_d       = key_q;
		res_d       = res_q;
		cell_op     = CELL_HOLD;
		cell_idx    = CW'(in_item.index);
		cell_cnt    = n_q;
		cell_wdata  = wval;
		imm_done    = 1'b0;
		imm_res     = '0;
		deliver     = 1'b0;
		deliver_res = res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					imm_done = 1'b1;
					unique case (in_item.action)
						ACT_PUSH: begin
							if (can_grow) begin
								cell_op    = CELL_WRITE;
								cell_idx   = n_q;
								n_d        = n_q + CW'(1);
								imm_res.ok = 1'b1;
							end
						end
						ACT_POP: begin
							if (n_q != '0) begin
								imm_done = 1'b0;
								tgt_d    = n_q - CW'(1);
								n_d      = n_q - CW'(1);
								find_d   = 1'b0;
								state_d  = ST_FWD;
							end
						end
						ACT_INSERT: begin
							if (idx_le && can_grow) begin
								cell_op    = CELL_INSERT;
								n_d        = n_q + CW'(1);
								imm_res.ok = 1'b1;
							end
						end
						ACT_ERASE: begin
							if (idx_lt) begin
								cell_op    = CELL_ERASE;
								n_d        = n_q - CW'(1);
								imm_res.ok = 1'b1;
							end
						end
						ACT_GET: begin
							if (idx_lt) begin
								imm_done = 1'b0;
								tgt_d    = CW'(in_item.index);
								find_d   = 1'b0;
								state_d  = ST_FWD;
							end
						end
						ACT_SET: begin
							if (idx_lt) begin
								cell_op    = CELL_WRITE;
								imm_res.ok = 1'b1;
							end
						end
						ACT_FIND: begin
							imm_done = 1'b0;
							key_d    = wval;
							find_d   = 1'b1;
							state_d  = ST_FWD;
						end
						ACT_CLEAR: begin
							n_d        = '0;
							imm_res.ok = 1'b1;
						end
						default: begin
							imm_done = 1'b1;
						end
					endcase
					imm_res.count_now = COUNT_W'(n_d);
					if (imm_done) begin
						if (out_free) begin
							deliver     = 1'b1;
							deliver_res = imm_res;
						end else begin
							res_d   = imm_res;
							state_d = ST_HOLD;
						end
					end
				end
			end
			ST_FWD: begin
				// The head cell holds list position s_q after s_q rotations
				res_d           = '0;
				res_d.count_now = COUNT_W'(n_q);
				if (find_q) begin
					if (s_q == n_q) begin
						state_d = ST_BACK;
					end else if (head == key_q) begin
						res_d.ok          = 1'b1;
						res_d.match_index = MATCH_W'(s_q);
						state_d           = ST_BACK;
					end else begin
						cell_op = CELL_ROT_DN;
						s_d     = s_q + CW'(1);
					end
				end else if (s_q == tgt_q) begin
					res_d.ok         = 1'b1;
					res_d.read_value = VALUE_W'(head);
					state_d          = ST_BACK;
				end else begin
					cell_op = CELL_ROT_DN;
					s_d     = s_q + CW'(1);
				end
			end
			ST_BACK: begin
				// Undo the rotations, then hand the result over
				if (s_q != '0) begin
					cell_op = CELL_ROT_UP;
					s_d     = s_q - CW'(1);
				end else if (out_free) begin
					deliver = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					deliver = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			s_q         <= '0;
			cap_q       <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			s_q     <= s_d;
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		tgt_q  <= tgt_d;
		find_q <= find_d;
		key_q  <= key_d;
		res_q  <= res_d;
		if (deliver) begin
			out_q <= deliver_res;
		end
	end

	`ILE_ASSERT_IMP(a_idle_aligned, clk, arst_n, state_q == ST_IDLE, s_q == '0, "ring not realigned")
	`ILE_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == ST_FWD, s_q <= n_q, "scan passed count")
	`ILE_ASSERT_IMP(a_hold_busy, clk, arst_n, state_q == ST_HOLD, out_valid_q, "held with free output")
	`ILE_ASSERT_NXT(a_count_still, clk, arst_n, !accept, $stable(n_q), "count moved without request")

endmodule

@@ src/indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of elements kept in a ring of cells, with indexed access.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready with in_item (action, index, value);
//   each gives exactly one result on out_valid/out_ready with out_item.
//   The capacity limit is to be written on cfg_valid/cfg_data only while no
//   request is in flight (not enforced by the block); cfg_ready is always high.
//   Push, insert, erase, set, clear and every refused request finish in the
//   accepting cycle: the result is registered there, and while the output is
//   free such requests go one per cycle.
//   Get at index k and pop (k = count - 1) rotate the ring k steps to bring
//   the element to the head cell and k steps back. Find rotates until the
//   first match or the end of the list and back. The rotation of the cell
//   ring sets how long these requests take.
//   When the receiver stalls, the result register holds the transaction and
//   one more finished result waits inside; then in_ready stays low.
//   Reset empties the list and sets the limit to 64; the element cells are
//   not cleared and read only after being written.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
	parameter int DEPTH         = ile_pkg::DEPTH_DEF,
	parameter int ELEMENT_WIDTH = ile_pkg::ELEM_W_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [ile_pkg::CAP_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  ile_pkg::in_item_t         in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output ile_pkg::out_item_t        out_item
);
	import ile_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	cell_op_t                 cell_op;
	logic [CW-1:0]            cell_idx;
	logic [CW-1:0]            cell_cnt;
	logic [ELEMENT_WIDTH-1:0] cell_wdata;
	logic [ELEMENT_WIDTH-1:0] elem [DEPTH];

	// Sequencer and result register
	ile_ctrl #(
		.DEPTH         (DEPTH),
		.ELEMENT_WIDTH (ELEMENT_WIDTH),
		.CW            (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.head       (elem[0]),
		.cell_op    (cell_op),
		.cell_idx   (cell_idx),
		.cell_cnt   (cell_cnt),
		.cell_wdata (cell_wdata)
	);

	// Ring of element cells, each linked to both neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		ile_cell #(
			.ELEMENT_WIDTH (ELEMENT_WIDTH),
			.CW            (CW)
		) u_cell (
			.clk   (clk),
			.op    (cell_op),
			.pos   (CW'(i)),
			.idx   (cell_idx),
			.cnt   (cell_cnt),
			.wdata (cell_wdata),
			.up    (elem[(i + 1) % DEPTH]),
			.dn    (elem[(i + DEPTH - 1) % DEPTH]),
			.q     (elem[i])
		);
	end

endmodule

@@ test/tb_indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// tb_indexed_list_engine
// Self-checking bench for the indexed list engine. A queue-based list model
// predicts ok, read value, match position and count for every request; each
// result leaving the block is compared against the oldest prediction. Short
// directed tests cover the empty list, every edit action and the capacity
// limit edges, then random traffic runs under several limits and idle mixes.
// ----------------------------------------------------------------------------
module tb_indexed_list_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import ile_pkg::*;

	localparam int LIST_DEPTH    = DEPTH_DEF;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 2 * LIST_DEPTH + 8;
	localparam int MAX_REPORTS   = 10;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 150;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data  = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_item_t          in_item   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_item;

	// List model state
	logic [VALUE_W-1:0] list_elems[$];
	logic [CAP_W-1:0]   list_limit = LIMIT_RESET;
	out_item_t          pending_results[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int errors         = 0;
	int reported       = 0;
	int requests_sent  = 0;
	int results_seen   = 0;
	int limit_writes   = 0;
	int quiet_cycles   = 0;

	indexed_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	// Room the list is allowed to grow to
	function automatic int unsigned room_limit();
		return (list_limit < LIST_DEPTH) ? list_limit : LIST_DEPTH;
	endfunction

	// Apply one request to the list model and return its result
	function automatic out_item_t apply_request(in_item_t req);
		out_item_t   res;
		int unsigned n;
		int unsigned idx;
		res = '0;
		n   = list_elems.size();
		idx = req.index;
		case (req.action)
			ACT_PUSH: begin
				if (n < room_limit()) begin
					list_elems.push_back(req.value);
					res.ok = 1'b1;
				end
			end
			ACT_POP: begin
				if (n > 0) begin
					res.read_value = list_elems.pop_back();
					res.ok = 1'b1;
				end
			end
			ACT_INSERT: begin
				if (idx <= n && n < room_limit()) begin
					if (idx == n)
						list_elems.push_back(req.value);
					else
						list_elems.insert(idx, req.value);
					res.ok = 1'b1;
				end
			end
			ACT_ERASE: begin
				if (idx < n) begin
					list_elems.delete(idx);
					res.ok = 1'b1;
				end
			end
			ACT_GET: begin
				if (idx < n) begin
					res.read_value = list_elems[idx];
					res.ok = 1'b1;
				end
			end
			ACT_SET: begin
				if (idx < n) begin
					list_elems[idx] = req.value;
					res.ok = 1'b1;
				end
			end
			ACT_FIND: begin
				for (int i = 0; i < n && !res.ok; i++) begin
					if (list_elems[i] == req.value) begin
						res.match_index = MATCH_W'(i);
						res.ok = 1'b1;
					end
				end
			end
			default: begin
				list_elems.delete();
				res.ok = 1'b1;
			end
		endcase
		res.count_now = COUNT_W'(list_elems.size());
		return res;
	endfunction

	// Drive one request, hold it until accepted, then record its prediction
	task automatic send_request(input action_t act, input logic [INDEX_W-1:0] idx,
		input logic [VALUE_W-1:0] val);
		in_item_t req;
		req.action = act;
		req.index  = idx;
		req.value  = val;
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(apply_request(req));
		requests_sent++;
	endtask

	// Drop valid and hold until every predicted result has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the capacity limit once the block has gone quiet
	task automatic write_limit(input logic [CAP_W-1:0] lim);
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= lim;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		list_limit = lim;
		limit_writes++;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return VALUE_W'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	// Mostly a live position, sometimes the first one past the end
	function automatic logic [INDEX_W-1:0] pick_index(input int unsigned n);
		if (n == 0 || $urandom_range(0, 9) == 0)
			return INDEX_W'(n);
		return INDEX_W'($urandom_range(0, n - 1));
	endfunction

	// One random request: mostly well-formed against the model, some noise
	task automatic send_random_request(input int grow_pct);
		int unsigned       n;
		int unsigned       roll;
		logic [VALUE_W-1:0] key;
		n    = list_elems.size();
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 12) begin
			send_request(action_t'($urandom_range(0, 7)), INDEX_W'($urandom_range(0, 127)),
				$urandom);
		end else if (n < room_limit() && roll < grow_pct) begin
			if ($urandom_range(0, 1) == 0)
				send_request(ACT_PUSH, INDEX_W'($urandom_range(0, 127)), pick_value());
			else
				send_request(ACT_INSERT, pick_index(n + 1), pick_value());
		end else begin
			case ($urandom_range(0, 49))
				0: send_request(ACT_CLEAR, '0, '0);
				1, 2, 3, 4, 5, 6, 7, 8, 9: send_request(ACT_POP, '0, '0);
				10, 11, 12, 13, 14, 15, 16, 17, 18: send_request(ACT_ERASE, pick_index(n), '0);
				19, 20, 21, 22, 23, 24, 25, 26, 27, 28:
					send_request(ACT_GET, pick_index(n), '0);
				29, 30, 31, 32, 33, 34, 35, 36, 37, 38:
					send_request(ACT_SET, pick_index(n), pick_value());
				default: begin
					if (n > 0 && $urandom_range(0, 9) < 6)
						key = list_elems[$urandom_range(0, n - 1)];
					else
						key = pick_value();
					send_request(ACT_FIND, INDEX_W'($urandom_range(0, 127)), key);
				end
			endcase
		end
	endtask

	task automatic test_empty_list();
		write_limit(LIMIT_RESET);
		send_request(ACT_POP, '0, '0);
		send_request(ACT_GET, '0, '0);
		send_request(ACT_FIND, '0, '0);
	endtask

	task automatic test_edit_ops();
		send_request(ACT_PUSH, '0, 32'hFFFF_FFFF);
		send_request(ACT_PUSH, '1, 32'h0000_0000);
		send_request(ACT_INSERT, 7'd0, 32'hA5A5_A5A5);
		send_request(ACT_INSERT, 7'd3, 32'h5A5A_5A5A);
		send_request(ACT_INSERT, 7'd5, 32'h1111_1111);
		send_request(ACT_GET, 7'd1, '0);
		send_request(ACT_SET, 7'd3, 32'h1234_5678);
		send_request(ACT_SET, 7'd4, 32'h2222_2222);
		send_request(ACT_FIND, '0, 32'h0000_0000);
		send_request(ACT_FIND, '0, 32'hDEAD_BEEF);
		send_request(ACT_ERASE, 7'd0, '0);
		send_request(ACT_ERASE, 7'd3, '0);
		send_request(ACT_GET, 7'd127, '0);
		send_request(ACT_POP, '0, '0);
	endtask

	// Full list, limit below the count, zero limit and oversized limit
	task automatic test_capacity_limit();
		write_limit(7'd2);
		send_request(ACT_PUSH, '0, 32'h3333_3333);
		send_request(ACT_INSERT, '0, 32'h4444_4444);
		write_limit(7'd1);
		send_request(ACT_GET, 7'd1, '0);
		send_request(ACT_FIND, '0, 32'hFFFF_FFFF);
		send_request(ACT_SET, 7'd0, 32'h0000_0001);
		write_limit(7'd0);
		send_request(ACT_CLEAR, '0, '0);
		send_request(ACT_PUSH, '0, 32'h5555_5555);
		write_limit(7'd127);
		send_request(ACT_PUSH, '0, 32'h8000_0000);
	endtask

	task automatic test_random_traffic();
		logic [CAP_W-1:0] lim;
		int               grow;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: lim = 7'd64;
				1: lim = 7'd3;
				2: lim = 7'd127;
				3: lim = 7'd1;
				4: lim = 7'd20;
				5: lim = 7'd0;
				6: lim = 7'd64;
				default: lim = CAP_W'($urandom_range(2, 63));
			endcase
			write_limit(lim);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			grow = (p % 2 == 0) ? 60 : 30;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// hold the sender mid-phase until the pipe is empty
				if (k == PHASE_ITEMS / 2)
					wait_for_results();
				send_random_request(grow);
			end
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// Randomly stall the result channel
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_result
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				if (reported < MAX_REPORTS)
					$display("%0t: result with nothing pending: ok=%0d rd=%h mi=%0d cnt=%0d",
						$realtime, out_item.ok, out_item.read_value, out_item.match_index,
						out_item.count_now);
				reported++;
			end else begin
				want = pending_results.pop_front();
				if (out_item.ok !== want.ok || out_item.read_value !== want.read_value ||
					out_item.match_index !== want.match_index ||
					out_item.count_now !== want.count_now) begin
					errors++;
					if (reported < MAX_REPORTS)
						$display("%0t: mismatch: expected ok=%0d rd=%h mi=%0d cnt=%0d, got ok=%0d rd=%h mi=%0d cnt=%0d",
							$realtime, want.ok, want.read_value, want.match_index,
							want.count_now, out_item.ok, out_item.read_value,
							out_item.match_index, out_item.count_now);
					reported++;
				end
			end
		end
	end

	// End the run if no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
			$display("tb_indexed_list_engine: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_edit_ops();
		test_capacity_limit();
		test_random_traffic();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d requests over all eight actions, %0d limit writes (0, 1, 64, 127)",
			requests_sent, limit_writes);
		$display("checked %0d results under four idle mixes, %0d mismatches",
			results_seen, errors);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb_indexed_list_engine: PASS");
		end else begin
			if (pending_results.size() != 0)
				$display("%0d predicted results never arrived", pending_results.size());
			$display("tb_indexed_list_engine: FAIL");
		end
		$finish;
	end

endmodule
